@@ rtl/tmmac_pkg.sv @@
// Shared types and constants for the tile multiply-accumulate unit.
`timescale 1ns / 1ps

package tmmac_pkg;

  localparam int TILE_DEF    = 8;   // default tile edge
  localparam int IDX_W       = 3;   // row/column field width
  localparam int DATA_W      = 32;  // Q16.16 element width
  localparam int FRAC_W      = 16;  // fractional bits
  localparam int REQ_W       = 3;   // request kind width
  localparam int IN_TDATA_W  = 40;  // row, col, value padded to bytes
  localparam int OUT_TDATA_W = 40;  // out_row, out_col, out_value padded to bytes

  typedef enum logic [REQ_W-1:0] {
    REQ_WR_A    = 3'd0,
    REQ_WR_B    = 3'd1,
    REQ_WR_D    = 3'd2,
    REQ_CLR_D   = 3'd3,
    REQ_COMPUTE = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN0,
    ST_DRAIN1,
    ST_WRITE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic             in_ready;
    logic             issue;     // present A/B/D read addresses for one k step
    logic             first;     // k step zero of an element
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic             load_out;  // capture the finished element
    logic             last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

@@ rtl/tmmac_ctrl.sv @@
// Sequencer for the element-by-element multiply-accumulate walk.
`timescale 1ns / 1ps

module tmmac_ctrl #(
  parameter int TILE = tmmac_pkg::TILE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [tmmac_pkg::REQ_W-1:0]    in_req_i,
  input  tmmac_pkg::dp_sts_t             sts_i,
  output tmmac_pkg::dp_cmd_t             cmd_o
);

  localparam logic [tmmac_pkg::IDX_W-1:0] LastIdx = tmmac_pkg::IDX_W'(TILE - 1);

  tmmac_pkg::state_e state_q, state_d;
  logic [tmmac_pkg::IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tmmac_pkg::ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    i_d            = i_q;
    j_d            = j_q;
    k_d            = k_q;
    cmd_o          = '0;
    cmd_o.i        = i_q;
    cmd_o.j        = j_q;
    cmd_o.k        = k_q;
    cmd_o.first    = (k_q == '0);
    cmd_o.last     = (i_q == LastIdx) && (j_q == LastIdx);
    case (state_q)
      tmmac_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i && (in_req_i == tmmac_pkg::REQ_COMPUTE)) begin
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          state_d = tmmac_pkg::ST_MAC;
        end
      end
      tmmac_pkg::ST_MAC: begin
        cmd_o.issue = 1'b1;
        if (k_q == LastIdx) begin
          k_d     = '0;
          state_d = tmmac_pkg::ST_DRAIN0;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      tmmac_pkg::ST_DRAIN0: state_d = tmmac_pkg::ST_DRAIN1;
      tmmac_pkg::ST_DRAIN1: state_d = tmmac_pkg::ST_WRITE;
      tmmac_pkg::ST_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (cmd_o.last) begin
            state_d = tmmac_pkg::ST_IDLE;
          end else begin
            state_d = tmmac_pkg::ST_MAC;
            if (j_q == LastIdx) begin
              j_d = '0;
              i_d = i_q + 1'b1;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        end
      end
      default: state_d = tmmac_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ rtl/tmmac_dp.sv @@
// Tile stores, multiply-accumulate pipeline, saturation and result register.
`timescale 1ns / 1ps

module tmmac_dp #(
  parameter int TILE = tmmac_pkg::TILE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tmmac_pkg::dp_cmd_t                cmd_i,
  output tmmac_pkg::dp_sts_t                sts_o,
  input  logic                              in_valid_i,
  input  logic [tmmac_pkg::REQ_W-1:0]       in_req_i,
  input  logic [tmmac_pkg::IDX_W-1:0]       in_row_i,
  input  logic [tmmac_pkg::IDX_W-1:0]       in_col_i,
  input  logic [tmmac_pkg::DATA_W-1:0]      in_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tmmac_pkg::IDX_W-1:0]       out_row_o,
  output logic [tmmac_pkg::IDX_W-1:0]       out_col_o,
  output logic [tmmac_pkg::DATA_W-1:0]      out_value_o,
  output logic                              out_last_o
);

  localparam int CELLS  = TILE * TILE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int DW     = tmmac_pkg::DATA_W;
  localparam int FW     = tmmac_pkg::FRAC_W;
  localparam int PROD_W = 2 * DW;
  localparam int ACC_W  = PROD_W + $clog2(TILE + 1);
  localparam int IW     = tmmac_pkg::IDX_W;

  logic [DW-1:0] a_mem [CELLS];
  logic [DW-1:0] b_mem [CELLS];
  logic [DW-1:0] d_mem [CELLS];
  logic [CELLS-1:0] d_vld_q;

  tmmac_pkg::req_e req;
  logic             in_acc, in_range;
  logic             a_we, b_we, d_ld_we, d_clr, d_we;
  logic [ADDR_W-1:0] wr_addr, a_rd_addr, b_rd_addr, d_addr, d_waddr;
  logic [DW-1:0]     d_wdata;

  logic signed [DW-1:0]     a_rd_q, b_rd_q;
  logic [DW-1:0]            d_rd_q;
  logic                     d_rd_vld_q;
  logic                     rd_vld_q, rd_first_q, mul_vld_q, mul_first_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [DW-1:0]            dm_q;
  logic signed [ACC_W-1:0]  acc_q, prod_ext, d_term;
  logic [ACC_W-FW-DW:0]     acc_top;
  logic                     no_sat;
  logic [DW-1:0]            result;
  logic                     out_valid_q;
  logic [IW-1:0]            out_row_q, out_col_q;
  logic [DW-1:0]            out_value_q;
  logic                     out_last_q;

  // Load side
  assign req      = tmmac_pkg::req_e'(in_req_i);
  assign in_acc   = in_valid_i && cmd_i.in_ready;
  assign in_range = ({1'b0, in_row_i} < (IW + 1)'(TILE)) &&
                    ({1'b0, in_col_i} < (IW + 1)'(TILE));
  assign wr_addr  = ADDR_W'(in_row_i * TILE + in_col_i);
  assign a_we     = in_acc && in_range && (req == tmmac_pkg::REQ_WR_A);
  assign b_we     = in_acc && in_range && (req == tmmac_pkg::REQ_WR_B);
  assign d_ld_we  = in_acc && in_range && (req == tmmac_pkg::REQ_WR_D);
  assign d_clr    = in_acc && (req == tmmac_pkg::REQ_CLR_D);

  // Compute side addressing
  assign a_rd_addr = ADDR_W'(cmd_i.i * TILE + cmd_i.k);
  assign b_rd_addr = ADDR_W'(cmd_i.k * TILE + cmd_i.j);
  assign d_addr    = ADDR_W'(cmd_i.i * TILE + cmd_i.j);

  // Loads and write-back never overlap: loads are only taken while idle
  assign d_we    = d_ld_we || cmd_i.load_out;
  assign d_waddr = d_ld_we ? wr_addr : d_addr;
  assign d_wdata = d_ld_we ? in_value_i : result;

  always_ff @(posedge clk_i) begin
    if (a_we) a_mem[wr_addr] <= in_value_i;
    if (b_we) b_mem[wr_addr] <= in_value_i;
    if (d_we) d_mem[d_waddr] <= d_wdata;
    a_rd_q     <= a_mem[a_rd_addr];
    b_rd_q     <= b_mem[b_rd_addr];
    d_rd_q     <= d_mem[d_addr];
    d_rd_vld_q <= d_vld_q[d_addr];
  end

  // D entries read as zero until written since the last clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= '0;
    end else if (d_clr) begin
      d_vld_q <= '0;
    end else if (d_we) begin
      d_vld_q[d_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      rd_first_q  <= 1'b0;
      mul_vld_q   <= 1'b0;
      mul_first_q <= 1'b0;
    end else begin
      rd_vld_q    <= cmd_i.issue;
      rd_first_q  <= cmd_i.first;
      mul_vld_q   <= rd_vld_q;
      mul_first_q <= rd_first_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_rd_q * b_rd_q;
    dm_q   <= d_rd_vld_q ? d_rd_q : '0;
  end

  // Exact sum: (D << 16) plus full products
  assign prod_ext = ACC_W'(prod_q);
  assign d_term   = ACC_W'($signed({dm_q, {FW{1'b0}}}));

  always_ff @(posedge clk_i) begin
    if (mul_vld_q) begin
      acc_q <= mul_first_q ? (d_term + prod_ext) : (acc_q + prod_ext);
    end
  end

  // Floor shift by 16 then clamp to 32 bits
  assign acc_top = acc_q[ACC_W-1:FW+DW-1];
  assign no_sat  = (&acc_top) || !(|acc_top);
  assign result  = no_sat ? acc_q[FW+DW-1:FW] :
                   (acc_q[ACC_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_row_q   <= cmd_i.i;
      out_col_q   <= cmd_i.j;
      out_value_q <= result;
      out_last_q  <= cmd_i.last;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign out_value_o    = out_value_q;
  assign out_last_o     = out_last_q;

endmodule

@@ rtl/tile_matrix_multiply_accumulate_unit.sv @@
// Top level of the tile matrix multiply-accumulate unit.
// Sequencing: a load or clear transfer is written to its tile on acceptance; a compute
//   transfer walks each element through the MAC, DRAIN0, DRAIN1 and WRITE states, and
//   WRITE waits for a free result register. Input: one load or clear per cycle while idle,
//   none during a compute; one shared 32x32 multiplier stepping k once per cycle.
// Reset: rst_ni asynchronous, active low; D reads as zero, A and B hold nothing defined.
`timescale 1ns / 1ps

module tile_matrix_multiply_accumulate_unit #(
  parameter int TILE = tmmac_pkg::TILE_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [2:0] row, [5:3] col, [37:6] value, [39:38] zero
  input  logic [tmmac_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // [2:0] req_type
  input  logic [tmmac_pkg::REQ_W-1:0]          s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [2:0] out_row, [5:3] out_col, [37:6] out_value, [39:38] zero
  output logic [tmmac_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                                 m_axis_tlast_o
);

  localparam int IW = tmmac_pkg::IDX_W;
  localparam int DW = tmmac_pkg::DATA_W;

  tmmac_pkg::dp_cmd_t cmd;
  tmmac_pkg::dp_sts_t sts;

  logic [IW-1:0] out_row, out_col;
  logic [DW-1:0] out_value;

  // Controller walks elements row-major and k within each element
  tmmac_ctrl #(
    .TILE (TILE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_req_i   (s_axis_tuser_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: tile memories, multiplier, accumulator, saturation, result register
  tmmac_dp #(
    .TILE (TILE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (s_axis_tvalid_i),
    .in_req_i    (s_axis_tuser_i),
    .in_row_i    (s_axis_tdata_i[2:0]),
    .in_col_i    (s_axis_tdata_i[5:3]),
    .in_value_i  (s_axis_tdata_i[37:6]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast_o)
  );

  // Input is taken only between computes; a pending final result does not block it
  assign s_axis_tready_o = cmd.in_ready;
  assign m_axis_tdata_o  = {2'b00, out_value, out_col, out_row};

endmodule

@@ rtl/tmmac_chk.sv @@
// Port-level checks for the tile multiply-accumulate unit, bound to the top level.
`timescale 1ns / 1ps

module tmmac_chk #(
  parameter int TILE = tmmac_pkg::TILE_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid_i,
  input logic                               s_axis_tready_o,
  input logic [tmmac_pkg::REQ_W-1:0]        s_axis_tuser_i,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [tmmac_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input logic                               m_axis_tlast_o
);

  // Held result stays put while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // Final element is the bottom-right corner
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |->
      (m_axis_tdata_o[2:0] == 3'(TILE - 1)) && (m_axis_tdata_o[5:3] == 3'(TILE - 1)))
    else $error("tlast away from last element");

  // A compute transfer closes the input side
  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == tmmac_pkg::REQ_COMPUTE) |=>
      !s_axis_tready_o)
    else $error("input taken during compute");

  // Mid-tile results only appear while the input side is closed
  a_mid_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input open with tile unfinished");

endmodule

bind tile_matrix_multiply_accumulate_unit tmmac_chk #(.TILE(TILE)) u_tmmac_chk (.*);

@@ verif/tb_tile_matrix_multiply_accumulate_unit.sv @@
// Self-checking testbench for the tile matrix multiply-accumulate unit.
`timescale 1ns / 1ps

module tb_tile_matrix_multiply_accumulate_unit;
  import tmmac_pkg::*;

  localparam int TILE       = TILE_DEF;
  localparam int CELLS      = TILE * TILE;
  localparam int IDLE_PCT   = 14;              // chance in a hundred of an idle cycle
  localparam int HOLD_AT    = 200;             // results seen before the long output stall
  localparam int HOLD_LEN   = 1500;            // cycles of that stall
  localparam int QUIET_MAX  = 20000;           // cycles with no transfer before giving up
  localparam int TAIL       = 4 * (TILE + 4);  // settle time once nothing is outstanding
  localparam int RAND_ITEMS = 300;

  localparam logic signed [71:0] SAT_HI = 72'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [71:0] SAT_LO = -72'sh0_0000_0000_8000_0000;

  typedef struct {
    req_e        kind;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    bit          drain;  // hold back until every pending result has come out
    bit          calm;   // no random idling on either side while this is offered
  } tile_req_t;

  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last;
  } tile_elem_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [REQ_W-1:0]       s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  tile_matrix_multiply_accumulate_unit #(.TILE(TILE)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  // Shadow copy of the three tiles
  logic [31:0] a_mem [CELLS];
  logic [31:0] b_mem [CELLS];
  logic [31:0] d_mem [CELLS];

  tile_req_t  req_queue[$];
  tile_elem_t tile_results_q[$];
  tile_req_t  offered;

  int  items_total, items_taken, computes, ignored, saturations;
  int  results_seen, mismatches, quiet;
  int  hold_left;
  bit  hold_done;
  bit  calm_q;
  bit  gen_drain, gen_calm;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Updates the shadow tiles for one accepted request and queues any tile it emits.
  function automatic void apply_request(input tile_req_t rq);
    logic signed [71:0] acc;
    logic signed [63:0] prod;
    logic [31:0]        upd [CELLS];
    int                 idx;
    bit                 in_tile;
    in_tile = (rq.row < TILE) && (rq.col < TILE);
    idx = rq.row * TILE + rq.col;
    case (rq.kind)
      REQ_WR_A: if (in_tile) a_mem[idx] = rq.value;
      REQ_WR_B: if (in_tile) b_mem[idx] = rq.value;
      REQ_WR_D: if (in_tile) d_mem[idx] = rq.value;
      REQ_CLR_D: begin
        foreach (d_mem[n]) d_mem[n] = '0;
      end
      REQ_COMPUTE: begin
        computes++;
        for (int i = 0; i < TILE; i++) begin
          for (int j = 0; j < TILE; j++) begin
            // exact sum at full width, floor shift, then clamp
            acc = $signed(d_mem[i * TILE + j]);
            acc = acc <<< FRAC_W;
            for (int k = 0; k < TILE; k++) begin
              prod = $signed(a_mem[i * TILE + k]) * $signed(b_mem[k * TILE + j]);
              acc  = acc + prod;
            end
            acc = acc >>> FRAC_W;
            if (acc > SAT_HI) begin
              acc = SAT_HI;
              saturations++;
            end else if (acc < SAT_LO) begin
              acc = SAT_LO;
              saturations++;
            end
            upd[i * TILE + j] = acc[31:0];
          end
        end
        for (int n = 0; n < CELLS; n++) begin
          d_mem[n] = upd[n];
          tile_results_q.push_back('{row: 3'(n / TILE), col: 3'(n % TILE),
                                     value: upd[n], last: (n == CELLS - 1)});
        end
      end
      default: ignored++;  // unused request kinds change nothing
    endcase
  endfunction

  function automatic void push_req(input req_e kind, input int row, input int col,
                                   input logic [31:0] value);
    req_queue.push_back('{kind: kind, row: 3'(row), col: 3'(col), value: value,
                          drain: gen_drain, calm: gen_calm});
    gen_drain = 1'b0;
  endfunction

  // Mostly small magnitudes so that sums stay in range; some wide and edge values.
  function automatic logic [31:0] pick_value();
    int roll;
    int v;
    roll = $urandom_range(99);
    if (roll < 55) begin
      v = int'($urandom_range((1 << 19) - 1)) - (1 << 18);
    end else if (roll < 75) begin
      v = int'($urandom_range((1 << 25) - 1)) - (1 << 24);
    end else if (roll < 90) begin
      v = $urandom;
    end else begin
      case ($urandom_range(5))
        0:       v = 0;
        1:       v = 1;
        2:       v = -1;
        3:       v = 32'h7FFF_FFFF;
        4:       v = 32'h8000_0000;
        default: v = 32'h0001_0000;
      endcase
    end
    return v;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // Stimulus and end of run
  initial begin
    int   seq;
    int   n_wr;
    int   roll;
    req_e k;
    foreach (a_mem[n]) a_mem[n] = '0;
    foreach (b_mem[n]) b_mem[n] = '0;
    foreach (d_mem[n]) d_mem[n] = '0;

    // A and B hold nothing after reset, so every element is loaded before any compute
    for (int r = 0; r < TILE; r++) begin
      for (int c = 0; c < TILE; c++) begin
        push_req(REQ_WR_A, r, c, int'($urandom_range((1 << 19) - 1)) - (1 << 18));
        push_req(REQ_WR_B, r, c, int'($urandom_range((1 << 19) - 1)) - (1 << 18));
      end
    end

    // Directed: D straight from reset, edge values, floor of a tiny negative,
    // saturation both ways, ignored kinds, clear, and recovery
    push_req(REQ_COMPUTE, 0, 0, '0);
    push_req(REQ_WR_D, 0, 0, 32'h7FFF_FFFF);
    push_req(REQ_WR_D, 7, 7, 32'h8000_0000);
    push_req(REQ_WR_D, 3, 4, 32'hFFFF_FFFF);
    push_req(REQ_WR_A, 1, 1, 32'hFFFF_FFFF);
    push_req(REQ_WR_B, 1, 1, 32'h0000_0001);
    push_req(REQ_WR_A, 0, 0, 32'h7FFF_FFFF);
    push_req(REQ_WR_B, 0, 0, 32'h7FFF_FFFF);
    push_req(REQ_WR_A, 7, 7, 32'h8000_0000);
    push_req(REQ_WR_B, 7, 7, 32'h7FFF_FFFF);
    for (int u = int'(REQ_COMPUTE) + 1; u < (1 << REQ_W); u++)
      push_req(req_e'(u), $urandom_range(7), $urandom_range(7), $urandom);
    push_req(REQ_COMPUTE, 7, 0, '0);
    push_req(REQ_COMPUTE, 0, 7, '0);
    push_req(REQ_CLR_D, 0, 0, '0);
    push_req(REQ_COMPUTE, 0, 0, '0);
    push_req(REQ_WR_A, 0, 0, 32'h0001_0000);
    push_req(REQ_WR_B, 0, 0, 32'hFFFF_0000);
    push_req(REQ_WR_A, 7, 7, 32'h0000_8000);
    push_req(REQ_WR_B, 7, 7, 32'h0002_0000);
    push_req(REQ_CLR_D, 0, 0, '0);

    // Random: runs of loads with random content closed by a compute,
    // with the odd clear and a little noise from unused kinds
    seq = 0;
    items_total = 0;
    while (items_total < RAND_ITEMS) begin
      gen_drain = (seq % 7 == 3) || (seq == 0);
      gen_calm  = (seq >= 6 && seq <= 9);
      if ($urandom_range(5) == 0) begin
        push_req(REQ_CLR_D, $urandom_range(7), $urandom_range(7), $urandom);
        items_total++;
      end
      n_wr = $urandom_range(24, 4);
      for (int w = 0; w < n_wr; w++) begin
        roll = $urandom_range(99);
        if (roll < 5) begin
          push_req(req_e'($urandom_range((1 << REQ_W) - 1, int'(REQ_COMPUTE) + 1)),
                   $urandom_range(7), $urandom_range(7), $urandom);
        end else begin
          k = (roll < 42) ? REQ_WR_A : (roll < 80) ? REQ_WR_B : REQ_WR_D;
          push_req(k, $urandom_range(7), $urandom_range(7), pick_value());
          items_total++;
        end
      end
      push_req(REQ_COMPUTE, $urandom_range(7), $urandom_range(7), $urandom);
      items_total++;
      seq++;
    end
    gen_calm = 1'b0;
    items_total = req_queue.size();

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    while (items_taken < items_total) @(posedge clk_i);
    while (tile_results_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    $display("Run covered %0d requests: %0d computes, %0d unused kinds ignored.",
             items_taken, computes, ignored);
    $display("Checked %0d tile elements, %0d of them clamped; %0d mismatches.",
             results_seen, saturations, mismatches);
    if (mismatches == 0) begin
      $display("tb_tile_matrix_multiply_accumulate_unit passed");
    end else begin
      $display("tb_tile_matrix_multiply_accumulate_unit failed");
    end
    $finish;
  end

  // Request driver: predicts on each accepted transfer, then offers the next one
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (s_tvalid && s_tready) begin
        apply_request(offered);
        items_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (req_queue.size() != 0 &&
            !(req_queue[0].drain && tile_results_q.size() != 0) &&
            (req_queue[0].calm || $urandom_range(99) >= IDLE_PCT)) begin
          offered = req_queue.pop_front();
          calm_q  = offered.calm;
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, offered.value, offered.col, offered.row};
          s_tuser  <= offered.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and output back-pressure
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (m_tvalid && m_tready) begin : check
        tile_elem_t want;
        results_seen++;
        if (tile_results_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result tdata=%h tlast=%b", m_tdata, m_tlast));
        end else begin
          want = tile_results_q.pop_front();
          if (m_tdata[2:0] !== want.row)
            note_mismatch($sformatf("row %0d, expected %0d", m_tdata[2:0], want.row));
          if (m_tdata[5:3] !== want.col)
            note_mismatch($sformatf("col %0d, expected %0d", m_tdata[5:3], want.col));
          if (m_tdata[37:6] !== want.value)
            note_mismatch($sformatf("value %h at (%0d,%0d), expected %h",
                                    m_tdata[37:6], want.row, want.col, want.value));
          if (m_tlast !== want.last)
            note_mismatch($sformatf("tlast %b at (%0d,%0d), expected %b",
                                    m_tlast, want.row, want.col, want.last));
        end
      end
      // one long stall mid-run so the unit backs up onto its input
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm_q || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog on stretches with no transfer on either side
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_MAX) begin
        $display("Watchdog: no transfer for %0d cycles", quiet);
        $display("tb_tile_matrix_multiply_accumulate_unit failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

endmodule
